/* rtl/lhm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lhm_pkg;

    localparam int CHANNEL_COUNT_DEF = 4;
    localparam int WINDOW_DEPTH_DEF  = 8;
    localparam int SAMPLE_BITS_DEF   = 10;

    localparam int CH_FIELD_W = 2;
    localparam int MASK_W     = 4;
    localparam int OUT_W      = 12;

    localparam logic [MASK_W-1:0] MASK_RESET = 4'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_RANK,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } t_state;

    // per-cycle command from the sequencer to the rank unit
    typedef struct packed {
        logic start;
        logic cmp;
        logic lower_slot;
        logic close;
        logic median;
        logic div_start;
    } t_rank_ctl;

endpackage

`default_nettype wire

/* rtl/lhm_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lhm_in_if #(
    parameter int SAMPLE_BITS = lhm_pkg::SAMPLE_BITS_DEF
) ();
    import lhm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CH_FIELD_W-1:0]  channel;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   prime;

    modport source (output valid, output channel, output sample, output prime, input ready);
    modport sink   (input valid, input channel, input sample, input prime, output ready);
endinterface

`default_nettype wire

/* rtl/lhm_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lhm_out_if ();
    import lhm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CH_FIELD_W-1:0] channel_out;
    logic [OUT_W-1:0]      filtered_q2;

    modport source (output valid, output channel_out, output filtered_q2, input ready);
    modport sink   (input valid, input channel_out, input filtered_q2, output ready);
endinterface

`default_nettype wire

/* rtl/lhm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhm_ram #(
    parameter  int WIDTH  = 10,
    parameter  int DEPTH  = 36,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr_a,
    input  wire logic [ADDR_W-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]  o_rdata_a,
    output logic      [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

/* rtl/lhm_rank_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhm_rank_unit #(
    parameter int WINDOW_DEPTH = lhm_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = lhm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire lhm_pkg::t_rank_ctl       i_ctl,
    input  wire logic [SAMPLE_BITS-1:0]   i_vi,
    input  wire logic [SAMPLE_BITS-1:0]   i_vj,
    output logic                          o_div_done,
    output logic [lhm_pkg::OUT_W-1:0]     o_filtered
);
    import lhm_pkg::*;

    localparam int SLOTS  = WINDOW_DEPTH + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int HALF   = WINDOW_DEPTH / 2;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(HALF + 1);
    localparam int NUM_W  = SUM_W + 3;
    localparam int DIV_L  = $clog2(WINDOW_DEPTH);
    localparam int RCP_SH = NUM_W + DIV_L;
    localparam int RCP_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam longint RCP_VAL = ((longint'(1) << RCP_SH) + longint'(WINDOW_DEPTH) - 1)
                                 / longint'(WINDOW_DEPTH);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);
    localparam int MED_W  = SAMPLE_BITS + 2;

    logic [SLOT_W-1:0]      r_cnt;
    logic                   r_div_done;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_med;
    logic [NUM_W-1:0]       r_q;

    logic                   w_less;
    logic [SLOT_W-1:0]      w_cnt;
    logic [NUM_W-1:0]       w_num;
    logic [PROD_W-1:0]      w_prod;
    logic [NUM_W-1:0]       w_quot;
    logic [MED_W-1:0]       w_med4;
    logic [OUT_W-1:0]       w_med_sat;
    logic [OUT_W-1:0]       w_mean_sat;

    // equal values rank by slot so the ranks form a permutation
    assign w_less = (i_vj < i_vi) || ((i_vj == i_vi) && i_ctl.lower_slot);
    assign w_cnt  = r_cnt + SLOT_W'(i_ctl.cmp && w_less);

    // divide by the window depth with a reciprocal multiply, exact over the numerator range
    assign w_num  = {r_sum, 3'b000};
    assign w_prod = PROD_W'(w_num) * PROD_W'(RCP);
    assign w_quot = NUM_W'(w_prod >> RCP_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= i_ctl.div_start;
            if (i_ctl.start || i_ctl.close) begin
                r_cnt <= '0;
            end else if (i_ctl.cmp) begin
                r_cnt <= w_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sum <= '0;
        end else if (i_ctl.close && !i_ctl.median && (w_cnt < SLOT_W'(HALF))) begin
            r_sum <= r_sum + SUM_W'(i_vi);
        end
        if (i_ctl.close && i_ctl.median && (w_cnt == SLOT_W'(HALF))) begin
            r_med <= i_vi;
        end
        if (i_ctl.div_start) begin
            r_q <= w_quot;
        end
    end

    assign w_med4 = {r_med, 2'b00};

    always_comb begin
        if ((w_med4 >> OUT_W) != '0) begin
            w_med_sat = '1;
        end else begin
            w_med_sat = OUT_W'(w_med4);
        end
        if ((r_q >> OUT_W) != '0) begin
            w_mean_sat = '1;
        end else begin
            w_mean_sat = OUT_W'(r_q);
        end
    end

    assign o_filtered = i_ctl.median ? w_med_sat : w_mean_sat;
    assign o_div_done = r_div_done;

endmodule

`default_nettype wire

/* rtl/lower_half_mean_window_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: with S = WINDOW_DEPTH + 1 slots, one shared comparator ranks every slot against
//   every other (mean mode leaves out the oldest slot); mean items then add a reciprocal
//   multiply by 8 / WINDOW_DEPTH; prime writes the sample into every slot of the window.
// Throughput: one item at a time; ready again in the cycle after the result enters the output
//   register, which holds it while the next item is taken.
// Reset: synchronous, active low, then a clearing pass over all CHANNEL_COUNT * S entries (36).
module lower_half_mean_window_filter_unit #(
    parameter int CHANNEL_COUNT = lhm_pkg::CHANNEL_COUNT_DEF,
    parameter int WINDOW_DEPTH  = lhm_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS   = lhm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [lhm_pkg::MASK_W-1:0] i_cfg_wdata,
    lhm_in_if.sink                          i_in,
    lhm_out_if.source                       o_out
);
    import lhm_pkg::*;

    localparam int SLOTS  = WINDOW_DEPTH + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DEPTH  = CHANNEL_COUNT * SLOTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CH_IW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    t_state                 r_state, n_state;
    t_rank_ctl              r_ctl, n_ctl;
    logic [MASK_W-1:0]      r_mask;
    logic [SLOT_W-1:0]      r_wp [CHANNEL_COUNT];
    logic [AW-1:0]          r_clr;
    logic [SLOT_W-1:0]      r_k, n_k;
    logic [SLOT_W-1:0]      r_j, n_j;
    logic [CH_FIELD_W-1:0]  r_ch;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_prime;
    logic                   r_median;
    logic                   r_zero;
    logic [AW-1:0]          r_base;
    logic [SLOT_W-1:0]      r_pos;
    logic [SLOT_W-1:0]      r_skip;
    logic                   r_out_valid;
    logic [CH_FIELD_W-1:0]  r_out_ch;
    logic [OUT_W-1:0]       r_out_val;

    logic                   w_accept;
    logic                   w_ch_ok;
    logic [CH_IW-1:0]       w_chi;
    logic [SLOT_W-1:0]      w_pos;
    logic [SLOT_W-1:0]      w_pos_next;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [SAMPLE_BITS-1:0] w_wdata;
    logic [AW-1:0]          w_ra;
    logic [AW-1:0]          w_rb;
    logic [SAMPLE_BITS-1:0] w_vi;
    logic [SAMPLE_BITS-1:0] w_vj;
    logic                   w_div_done;
    logic [OUT_W-1:0]       w_filtered;
    logic                   w_load_out;
    logic                   w_skip_i;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_ch_ok    = (32'(i_in.channel) < CHANNEL_COUNT);
    assign w_chi      = CH_IW'(i_in.channel);
    assign w_pos      = r_wp[w_chi];
    assign w_pos_next = (w_pos == SLOT_W'(SLOTS - 1)) ? '0 : (w_pos + SLOT_W'(1));
    assign w_skip_i   = !r_median && (r_k == r_skip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ctl   <= '0;
        end else begin
            r_state <= n_state;
            r_ctl   <= n_ctl;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_k              = r_k;
        n_j              = r_j;
        n_ctl            = '0;
        n_ctl.median     = r_median;
        w_we             = 1'b0;
        w_waddr          = r_base + AW'(r_pos);
        w_wdata          = r_sample;
        w_ra             = r_base + AW'(r_k);
        w_rb             = r_base + AW'(r_j);
        w_load_out       = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_ctl.start = 1'b1;
                    n_k         = '0;
                    n_state     = w_ch_ok ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                w_we = 1'b1;
                if (r_prime) begin
                    w_waddr = r_base + AW'(r_k);
                end
                if (!r_prime || (r_k == SLOT_W'(SLOTS - 1))) begin
                    n_k     = '0;
                    n_j     = '0;
                    n_state = ST_RANK;
                end else begin
                    n_k = r_k + SLOT_W'(1);
                end
            end
            ST_RANK: begin
                // mean mode leaves out the oldest slot on both sides
                n_ctl.cmp        = !w_skip_i && !(!r_median && (r_j == r_skip));
                n_ctl.lower_slot = (r_j < r_k);
                n_ctl.close      = (r_j == SLOT_W'(SLOTS - 1)) && !w_skip_i;
                if (r_j == SLOT_W'(SLOTS - 1)) begin
                    n_j = '0;
                    if (r_k == SLOT_W'(SLOTS - 1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_k = r_k + SLOT_W'(1);
                    end
                end else begin
                    n_j = r_j + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                n_ctl.div_start = !r_median;
                n_state         = r_median ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= MASK_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_wp[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_accept && w_ch_ok && !i_in.prime) begin
                r_wp[w_chi] <= w_pos_next;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_j <= n_j;
        if (w_accept) begin
            r_ch     <= i_in.channel;
            r_sample <= i_in.sample;
            r_prime  <= i_in.prime;
            r_median <= r_mask[i_in.channel];
            r_zero   <= !w_ch_ok;
            r_base   <= AW'(w_chi) * AW'(SLOTS);
            r_pos    <= w_pos;
            r_skip   <= i_in.prime ? w_pos : w_pos_next;
        end
        if (w_load_out) begin
            r_out_ch  <= r_ch;
            r_out_val <= r_zero ? '0 : w_filtered;
        end
    end

    lhm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_ra),
        .i_raddr_b (w_rb),
        .o_rdata_a (w_vi),
        .o_rdata_b (w_vj)
    );

    lhm_rank_unit #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_rank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl),
        .i_vi       (w_vi),
        .i_vj       (w_vj),
        .o_div_done (w_div_done),
        .o_filtered (w_filtered)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.channel_out = r_out_ch;
    assign o_out.filtered_q2 = r_out_val;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divide finished outside the divide state");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded without a finished item");

endmodule

`default_nettype wire
